// ===== rtl/chassis_lag_model_step_macros.svh =====
// Assertion macros for the chassis lag model step block.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef CHASSIS_LAG_MODEL_STEP_MACROS_SVH
`define CHASSIS_LAG_MODEL_STEP_MACROS_SVH

// same-cycle implication
`define CLMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLMS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/clms_pkg.sv =====
// Shared constants, types and state codes for the chassis lag model step.
// No dependencies.
package clms_pkg;

    localparam int FRAC_BITS         = 16;
    localparam int STEER_RESET_ANGLE = 0;
    localparam int MICRO             = 1000000;

    localparam int ACC_W    = 16 + FRAC_BITS;
    localparam int MUL_A_W  = ACC_W + 3;
    localparam int MUL_B_W  = 21;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int DVSR_W   = 21;
    localparam int DIV_ITER = (PROD_W + 3) / 4;
    localparam int MAG_W    = 4 * DIV_ITER;
    localparam int CNT_W    = $clog2(DIV_ITER + 1);
    localparam int DATA_W   = 136;
    localparam int MODE_W   = 49;
    localparam int MODE_LSB = 80;

    typedef enum logic [2:0] {
        CFG_SPEED_TAU_RISE,
        CFG_SPEED_TAU_FALL,
        CFG_STEER_TAU_RISE,
        CFG_STEER_TAU_FALL,
        CFG_BRAKE_TAU,
        CFG_ACCEL_LIMIT,
        CFG_BRAKE_DECEL_GAIN
    } t_cfg_index;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_V,
        S_DIV_V,
        S_MUL_LIM,
        S_DIV_LIM,
        S_MUL_LOSS,
        S_DIV_LOSS,
        S_VUPD,
        S_MUL_ACC,
        S_DIV_ACC,
        S_MUL_BL,
        S_DIV_BL,
        S_MUL_ST,
        S_DIV_ST,
        S_MUL_PR,
        S_DIV_PR,
        S_MUL_DEC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                     start;
        logic signed [PROD_W-1:0] dividend;
        logic [DVSR_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [PROD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/clms_div.sv =====
// Iterative signed floor divider, four quotient bits per cycle.
// Depends on clms_pkg.
module clms_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clms_pkg::t_div_req i_req,
    output clms_pkg::t_div_rsp o_rsp
);

    logic                               r_busy;
    logic                               r_done;
    logic [clms_pkg::CNT_W-1:0]         r_cnt;
    logic [clms_pkg::DVSR_W:0]          r_rem;
    logic [clms_pkg::MAG_W-1:0]         r_num;
    logic                               r_neg;
    logic [clms_pkg::DVSR_W-1:0]        r_dvsr;
    logic signed [clms_pkg::PROD_W-1:0] r_quo;

    logic [clms_pkg::DVSR_W:0]          c_rem;
    logic [clms_pkg::MAG_W-1:0]         c_num;
    logic signed [clms_pkg::PROD_W-1:0] c_abs;
    logic signed [clms_pkg::PROD_W-1:0] c_q;
    logic                               c_last;

    assign c_abs  = i_req.dividend[clms_pkg::PROD_W-1] ? -i_req.dividend : i_req.dividend;
    assign c_q    = signed'(r_num[clms_pkg::PROD_W-1:0]);
    assign c_last = (r_cnt == clms_pkg::CNT_W'(clms_pkg::DIV_ITER));

    // restoring step, quotient bits shift into the numerator register
    always_comb begin
        c_rem = r_rem;
        c_num = r_num;
        for (int k = 0; k < 4; k++) begin
            c_rem = {c_rem[clms_pkg::DVSR_W-1:0], c_num[clms_pkg::MAG_W-1]};
            c_num = {c_num[clms_pkg::MAG_W-2:0], 1'b0};
            if (c_rem >= {1'b0, r_dvsr}) begin
                c_rem    = c_rem - {1'b0, r_dvsr};
                c_num[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (c_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg  <= i_req.dividend[clms_pkg::PROD_W-1];
            r_num  <= clms_pkg::MAG_W'(unsigned'(c_abs));
            r_rem  <= '0;
            r_dvsr <= i_req.divisor;
        end else if (r_busy && !c_last) begin
            r_num <= c_num;
            r_rem <= c_rem;
        end else if (r_busy) begin
            // floor for negative dividends
            r_quo <= r_neg ? (-c_q - clms_pkg::PROD_W'(r_rem != '0)) : c_q;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/chassis_lag_model_step.sv =====
// Top level of the chassis lag model step: sequencer, shared multiplier, state.
// Depends on clms_pkg, clms_div and chassis_lag_model_step_macros.svh.
//
//  channel   dir  handshake                     payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  i_s_axis_tdata, 136b
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  o_m_axis_tdata, 136b
//  cfg       in   i_cfg_valid/o_cfg_ready          i_cfg_index 3b, i_cfg_data 12b
//
// A request runs from accept to result valid as seven divider passes (start, 14 steps
// of 4 quotient bits, final, done) plus ten sequencer steps; the acceleration
// division is skipped on a zero step or a clamp.
// Reset is synchronous, active low. Input ready is low while a request runs and
// returns in the same cycle that the output register shows the result; a finished result waits in the
// output register while the next request is taken, and the sequencer holds its
// last step if that register is still full.
`include "chassis_lag_model_step_macros.svh"
module chassis_lag_model_step (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // step_us, target_velocity, target_steer, target_pressure, target_brake_level,
    // drive_mode_in, drive_shift_in, steer_mode_in, ehb_status_in, ehb_mode_in,
    // pressure_valid_in, brake_fault_in, zero pad
    input  logic [135:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // velocity, acceleration, steer_angle, brake_press, brake_level,
    // drive_mode_out, drive_shift_out, steer_mode_out, ehb_status_out, ehb_mode_out,
    // pressure_valid_out, brake_fault_out, zero pad
    output logic [135:0] o_m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [11:0]  i_cfg_data
);

    // configuration
    logic [9:0]  r_spd_rise, r_spd_fall, r_str_rise, r_str_fall, r_brk_tau, r_gain;
    logic [11:0] r_acc_lim;

    clms_pkg::t_state r_state, n_state;
    logic             r_issued;

    logic [15:0]        r_dt, r_tv, r_tp, r_tb;
    logic signed [15:0] r_ts;
    logic [clms_pkg::MODE_W-1:0] r_mode;

    logic [clms_pkg::ACC_W-1:0]        r_vel, r_vold, r_vlag, r_lim, r_loss, r_press, r_blev;
    logic signed [clms_pkg::ACC_W-1:0] r_steer;
    logic [clms_pkg::ACC_W+1:0]        r_decel;
    logic                              r_clamp;
    logic signed [15:0]                r_acc;
    logic signed [clms_pkg::PROD_W-1:0] r_prod;

    logic                 r_out_valid;
    logic [clms_pkg::DATA_W-1:0] r_out_data;

    logic c_in_acc, c_is_div, c_out_free;
    logic [9:0] c_tau_v, c_tau_s;
    logic signed [clms_pkg::MUL_A_W-1:0] c_mul_a;
    logic signed [clms_pkg::MUL_B_W-1:0] c_mul_b;
    logic signed [clms_pkg::PROD_W-1:0]  c_prod, c_qs;
    logic signed [clms_pkg::ACC_W:0]     c_diff;
    logic signed [clms_pkg::ACC_W+2:0]   c_dv, c_vold, c_limx, c_vlim, c_vnew;
    logic [clms_pkg::DATA_W-1:0]         c_out;

    clms_pkg::t_div_req w_div_req;
    clms_pkg::t_div_rsp w_div_rsp;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == clms_pkg::S_IDLE);
    assign c_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign c_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign c_is_div = (r_state == clms_pkg::S_DIV_V)   || (r_state == clms_pkg::S_DIV_LIM) ||
                      (r_state == clms_pkg::S_DIV_LOSS) || (r_state == clms_pkg::S_DIV_ACC) ||
                      (r_state == clms_pkg::S_DIV_BL)  || (r_state == clms_pkg::S_DIV_ST) ||
                      (r_state == clms_pkg::S_DIV_PR);

    // tau choice against the demand
    assign c_tau_v = ({r_tv, {clms_pkg::FRAC_BITS{1'b0}}} > r_vel) ? r_spd_rise : r_spd_fall;
    assign c_tau_s = (r_steer < signed'({r_ts, {clms_pkg::FRAC_BITS{1'b0}}}))
                     ? r_str_rise : r_str_fall;

    assign c_diff = signed'({1'b0, r_vel}) - signed'({1'b0, r_vold});

    always_comb begin
        c_mul_a = '0;
        c_mul_b = '0;
        case (r_state)
            clms_pkg::S_MUL_V: begin
                c_mul_a = signed'(clms_pkg::MUL_A_W'(r_vel));
                c_mul_b = signed'(clms_pkg::MUL_B_W'(c_tau_v));
            end
            clms_pkg::S_MUL_LIM: begin
                c_mul_a = signed'(clms_pkg::MUL_A_W'(r_acc_lim));
                c_mul_b = signed'(clms_pkg::MUL_B_W'(r_dt));
            end
            clms_pkg::S_MUL_LOSS: begin
                c_mul_a = signed'(clms_pkg::MUL_A_W'(r_decel));
                c_mul_b = signed'(clms_pkg::MUL_B_W'(r_dt));
            end
            clms_pkg::S_MUL_ACC: begin
                c_mul_a = clms_pkg::MUL_A_W'(c_diff);
                c_mul_b = signed'(clms_pkg::MUL_B_W'(clms_pkg::MICRO));
            end
            clms_pkg::S_MUL_BL: begin
                c_mul_a = signed'(clms_pkg::MUL_A_W'(r_blev));
                c_mul_b = signed'(clms_pkg::MUL_B_W'(r_brk_tau));
            end
            clms_pkg::S_MUL_ST: begin
                c_mul_a = clms_pkg::MUL_A_W'(r_steer);
                c_mul_b = signed'(clms_pkg::MUL_B_W'(c_tau_s));
            end
            clms_pkg::S_MUL_PR: begin
                c_mul_a = signed'(clms_pkg::MUL_A_W'(r_press));
                c_mul_b = signed'(clms_pkg::MUL_B_W'(r_brk_tau));
            end
            clms_pkg::S_MUL_DEC: begin
                c_mul_a = signed'(clms_pkg::MUL_A_W'(r_press));
                c_mul_b = signed'(clms_pkg::MUL_B_W'(r_gain));
            end
            default: begin
                c_mul_a = '0;
                c_mul_b = '0;
            end
        endcase
    end

    assign c_prod = c_mul_a * c_mul_b;

    // divider operands
    always_comb begin
        w_div_req.start    = c_is_div && !r_issued;
        w_div_req.dividend = r_prod;
        w_div_req.divisor  = clms_pkg::DVSR_W'(clms_pkg::MICRO);
        case (r_state)
            clms_pkg::S_DIV_V: begin
                w_div_req.dividend = r_prod + signed'(clms_pkg::PROD_W'(
                                     {r_tv, {clms_pkg::FRAC_BITS{1'b0}}}));
                w_div_req.divisor  = clms_pkg::DVSR_W'(c_tau_v) + clms_pkg::DVSR_W'(1);
            end
            clms_pkg::S_DIV_LIM: begin
                w_div_req.dividend = r_prod <<< clms_pkg::FRAC_BITS;
            end
            clms_pkg::S_DIV_ACC: begin
                w_div_req.divisor  = clms_pkg::DVSR_W'(r_dt);
            end
            clms_pkg::S_DIV_BL: begin
                w_div_req.dividend = r_prod + signed'(clms_pkg::PROD_W'(
                                     {r_tb, {clms_pkg::FRAC_BITS{1'b0}}}));
                w_div_req.divisor  = clms_pkg::DVSR_W'(r_brk_tau) + clms_pkg::DVSR_W'(1);
            end
            clms_pkg::S_DIV_ST: begin
                w_div_req.dividend = r_prod + clms_pkg::PROD_W'(
                                     signed'({r_ts, {clms_pkg::FRAC_BITS{1'b0}}}));
                w_div_req.divisor  = clms_pkg::DVSR_W'(c_tau_s) + clms_pkg::DVSR_W'(1);
            end
            clms_pkg::S_DIV_PR: begin
                w_div_req.dividend = r_prod + signed'(clms_pkg::PROD_W'(
                                     {r_tp, {clms_pkg::FRAC_BITS{1'b0}}}));
                w_div_req.divisor  = clms_pkg::DVSR_W'(r_brk_tau) + clms_pkg::DVSR_W'(1);
            end
            default: begin
                w_div_req.dividend = r_prod;
            end
        endcase
    end

    clms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // rate limit, brake loss, clamp
    always_comb begin
        c_vold = signed'(clms_pkg::ACC_W'(0) + (clms_pkg::ACC_W+3)'(r_vel));
        c_limx = signed'((clms_pkg::ACC_W+3)'(r_lim));
        c_dv   = signed'((clms_pkg::ACC_W+3)'(r_vlag)) - c_vold;
        if (c_dv > c_limx) begin
            c_vlim = c_vold + c_limx;
        end else if (-c_dv > c_limx) begin
            c_vlim = c_vold - c_limx;
        end else begin
            c_vlim = signed'((clms_pkg::ACC_W+3)'(r_vlag));
        end
        c_vnew = c_vlim - signed'((clms_pkg::ACC_W+3)'(r_loss));
    end

    assign c_qs = w_div_rsp.quotient >>> clms_pkg::FRAC_BITS;

    always_comb begin
        n_state = r_state;
        case (r_state)
            clms_pkg::S_IDLE:     if (c_in_acc) n_state = clms_pkg::S_MUL_V;
            clms_pkg::S_MUL_V:    n_state = clms_pkg::S_DIV_V;
            clms_pkg::S_DIV_V:    if (w_div_rsp.done) n_state = clms_pkg::S_MUL_LIM;
            clms_pkg::S_MUL_LIM:  n_state = clms_pkg::S_DIV_LIM;
            clms_pkg::S_DIV_LIM:  if (w_div_rsp.done) n_state = clms_pkg::S_MUL_LOSS;
            clms_pkg::S_MUL_LOSS: n_state = clms_pkg::S_DIV_LOSS;
            clms_pkg::S_DIV_LOSS: if (w_div_rsp.done) n_state = clms_pkg::S_VUPD;
            clms_pkg::S_VUPD:     n_state = clms_pkg::S_MUL_ACC;
            clms_pkg::S_MUL_ACC: begin
                if (r_clamp || r_dt == '0) n_state = clms_pkg::S_MUL_BL;
                else                       n_state = clms_pkg::S_DIV_ACC;
            end
            clms_pkg::S_DIV_ACC:  if (w_div_rsp.done) n_state = clms_pkg::S_MUL_BL;
            clms_pkg::S_MUL_BL:   n_state = clms_pkg::S_DIV_BL;
            clms_pkg::S_DIV_BL:   if (w_div_rsp.done) n_state = clms_pkg::S_MUL_ST;
            clms_pkg::S_MUL_ST:   n_state = clms_pkg::S_DIV_ST;
            clms_pkg::S_DIV_ST:   if (w_div_rsp.done) n_state = clms_pkg::S_MUL_PR;
            clms_pkg::S_MUL_PR:   n_state = clms_pkg::S_DIV_PR;
            clms_pkg::S_DIV_PR:   if (w_div_rsp.done) n_state = clms_pkg::S_MUL_DEC;
            clms_pkg::S_MUL_DEC:  n_state = clms_pkg::S_OUT;
            clms_pkg::S_OUT:      if (c_out_free) n_state = clms_pkg::S_IDLE;
            default:              n_state = clms_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clms_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign c_out = {7'b0, r_mode,
                    r_blev[clms_pkg::ACC_W-1:clms_pkg::FRAC_BITS],
                    r_press[clms_pkg::ACC_W-1:clms_pkg::FRAC_BITS],
                    r_steer[clms_pkg::ACC_W-1:clms_pkg::FRAC_BITS],
                    r_acc,
                    r_vel[clms_pkg::ACC_W-1:clms_pkg::FRAC_BITS]};

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd_rise  <= 10'd150;
            r_spd_fall  <= 10'd200;
            r_str_rise  <= 10'd80;
            r_str_fall  <= 10'd40;
            r_brk_tau   <= 10'd80;
            r_acc_lim   <= 12'd300;
            r_gain      <= 10'd115;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (clms_pkg::t_cfg_index'(i_cfg_index))
                    clms_pkg::CFG_SPEED_TAU_RISE:   r_spd_rise <= i_cfg_data[9:0];
                    clms_pkg::CFG_SPEED_TAU_FALL:   r_spd_fall <= i_cfg_data[9:0];
                    clms_pkg::CFG_STEER_TAU_RISE:   r_str_rise <= i_cfg_data[9:0];
                    clms_pkg::CFG_STEER_TAU_FALL:   r_str_fall <= i_cfg_data[9:0];
                    clms_pkg::CFG_BRAKE_TAU:        r_brk_tau  <= i_cfg_data[9:0];
                    clms_pkg::CFG_ACCEL_LIMIT:      r_acc_lim  <= i_cfg_data;
                    clms_pkg::CFG_BRAKE_DECEL_GAIN: r_gain     <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (w_div_req.start)     r_issued <= 1'b1;
            else if (w_div_rsp.done) r_issued <= 1'b0;
            if (r_state == clms_pkg::S_OUT && c_out_free) r_out_valid <= 1'b1;
            else if (i_m_axis_tready)                     r_out_valid <= 1'b0;
        end
    end

    // model state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel   <= '0;
            r_steer <= clms_pkg::ACC_W'(signed'(clms_pkg::STEER_RESET_ANGLE) <<<
                       clms_pkg::FRAC_BITS);
            r_press <= '0;
            r_blev  <= '0;
            r_decel <= '0;
            r_mode  <= '0;
        end else begin
            if (c_in_acc) begin
                r_mode <= i_s_axis_tdata[clms_pkg::MODE_LSB +: clms_pkg::MODE_W];
            end
            if (r_state == clms_pkg::S_VUPD) begin
                r_vel <= c_vnew[clms_pkg::ACC_W+2] ? '0 : c_vnew[clms_pkg::ACC_W-1:0];
            end
            if (w_div_rsp.done) begin
                case (r_state)
                    clms_pkg::S_DIV_BL: r_blev  <= w_div_rsp.quotient[clms_pkg::ACC_W-1:0];
                    clms_pkg::S_DIV_ST: r_steer <= w_div_rsp.quotient[clms_pkg::ACC_W-1:0];
                    clms_pkg::S_DIV_PR: r_press <= w_div_rsp.quotient[clms_pkg::ACC_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == clms_pkg::S_MUL_DEC) begin
                r_decel <= c_prod[clms_pkg::ACC_W+9:8];
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (c_in_acc) begin
            r_dt <= i_s_axis_tdata[15:0];
            r_tv <= i_s_axis_tdata[31:16];
            r_ts <= signed'(i_s_axis_tdata[47:32]);
            r_tp <= i_s_axis_tdata[63:48];
            r_tb <= i_s_axis_tdata[79:64];
        end
        r_prod <= c_prod;
        if (r_state == clms_pkg::S_VUPD) begin
            r_vold  <= r_vel;
            r_clamp <= c_vnew[clms_pkg::ACC_W+2];
            r_acc   <= '0;
        end
        if (w_div_rsp.done) begin
            case (r_state)
                clms_pkg::S_DIV_V:    r_vlag <= w_div_rsp.quotient[clms_pkg::ACC_W-1:0];
                clms_pkg::S_DIV_LIM:  r_lim  <= w_div_rsp.quotient[clms_pkg::ACC_W-1:0];
                clms_pkg::S_DIV_LOSS: r_loss <= w_div_rsp.quotient[clms_pkg::ACC_W-1:0];
                clms_pkg::S_DIV_ACC: begin
                    if (c_qs > signed'(clms_pkg::PROD_W'(32767)))
                        r_acc <= 16'sd32767;
                    else if (c_qs < -signed'(clms_pkg::PROD_W'(32768)))
                        r_acc <= -16'sd32768;
                    else
                        r_acc <= c_qs[15:0];
                end
                default: ;
            endcase
        end
        if (r_state == clms_pkg::S_OUT && c_out_free) begin
            r_out_data <= c_out;
        end
    end

    `CLMS_ASSERT_NXT(a_busy_after_req, c_in_acc, !o_s_axis_tready, "ready after accept")
    `CLMS_ASSERT_IMP(a_start_idle_div, w_div_req.start, !w_div_rsp.busy, "divider restarted")
    `CLMS_ASSERT_IMP(a_done_in_div, w_div_rsp.done, c_is_div && r_issued, "stray divide done")
    `CLMS_ASSERT_IMP(a_out_from_seq, $rose(o_m_axis_tvalid), $past(r_state) == clms_pkg::S_OUT,
                     "result without sequence end")

endmodule

// ===== tb/chassis_lag_model_step_tb.sv =====
// Testbench for chassis_lag_model_step: directed and random ticks checked
// against a fixed-point chassis lag predictor. Depends on clms_pkg and the RTL.
`timescale 1ns / 100ps

class lag_scoreboard;
    logic [135:0] pending_q[$];
    int           fail_cnt;

    // config and chassis state
    int unsigned  tau_v_rise, tau_v_fall, tau_s_rise, tau_s_fall, tau_b, acc_lim, dec_gain;
    longint       vel_fx, steer_fx, press_fx, blev_fx, decel_fx;

    function void init();
        tau_v_rise = 150; tau_v_fall = 200; tau_s_rise = 80; tau_s_fall = 40;
        tau_b = 80; acc_lim = 300; dec_gain = 115;
        vel_fx = 0; steer_fx = 0; press_fx = 0; blev_fx = 0; decel_fx = 0;
        fail_cnt = 0;
    endfunction

    function void set_reg(clms_pkg::t_cfg_index idx, logic [11:0] val);
        case (idx)
            clms_pkg::CFG_SPEED_TAU_RISE:   tau_v_rise = 32'(val[9:0]);
            clms_pkg::CFG_SPEED_TAU_FALL:   tau_v_fall = 32'(val[9:0]);
            clms_pkg::CFG_STEER_TAU_RISE:   tau_s_rise = 32'(val[9:0]);
            clms_pkg::CFG_STEER_TAU_FALL:   tau_s_fall = 32'(val[9:0]);
            clms_pkg::CFG_BRAKE_TAU:        tau_b = 32'(val[9:0]);
            clms_pkg::CFG_ACCEL_LIMIT:      acc_lim = 32'(val);
            clms_pkg::CFG_BRAKE_DECEL_GAIN: dec_gain = 32'(val[9:0]);
            default: ;
        endcase
    endfunction

    function longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function longint lag_step(longint old, longint demand, int unsigned tau);
        return fdiv(longint'(tau) * old + demand * 65536, longint'(tau) + 1);
    endfunction

    function void note_tick(logic [135:0] d);
        longint dt, tv, ts, tp, tb, old_v, v, lim, accel;
        bit clamped;
        logic [135:0] res;
        dt = d[15:0]; tv = d[31:16]; ts = $signed(d[47:32]); tp = d[63:48]; tb = d[79:64];
        clamped = 0;
        old_v = vel_fx;
        v = lag_step(old_v, tv, (tv * 65536 > old_v) ? tau_v_rise : tau_v_fall);
        lim = (longint'(acc_lim) * dt * 65536) / 1000000;
        if (v - old_v > lim) v = old_v + lim;
        else if (old_v - v > lim) v = old_v - lim;
        v -= (decel_fx * dt) / 1000000;
        if (v < 0) begin
            v = 0;
            clamped = 1;
        end
        vel_fx = v;
        blev_fx = lag_step(blev_fx, tb, tau_b);
        accel = 0;
        if (!clamped && dt != 0) begin
            accel = fdiv(fdiv((v - old_v) * 1000000, dt), 65536);
            if (accel > 32767) accel = 32767;
            if (accel < -32768) accel = -32768;
        end
        steer_fx = lag_step(steer_fx, ts, (steer_fx < ts * 65536) ? tau_s_rise : tau_s_fall);
        press_fx = lag_step(press_fx, tp, tau_b);
        decel_fx = (press_fx * longint'(dec_gain)) >>> 8;
        res = '0;
        res[15:0]   = 16'(vel_fx / 65536);
        res[31:16]  = 16'(accel);
        res[47:32]  = 16'(fdiv(steer_fx, 65536));
        res[63:48]  = 16'(press_fx / 65536);
        res[79:64]  = 16'(blev_fx / 65536);
        res[128:80] = d[128:80];
        pending_q.push_back(res);
    endfunction

    function void check_result(logic [135:0] got);
        logic [135:0] exp_d;
        if (pending_q.size() == 0) begin
            $error("unexpected result %h", got);
            fail_cnt++;
            return;
        end
        exp_d = pending_q.pop_front();
        cmp("velocity", exp_d[15:0], got[15:0]);
        cmp("acceleration", exp_d[31:16], got[31:16]);
        cmp("steer_angle", exp_d[47:32], got[47:32]);
        cmp("brake_press", exp_d[63:48], got[63:48]);
        cmp("brake_level", exp_d[79:64], got[79:64]);
        cmp("drive_mode_out", 16'(exp_d[87:80]), 16'(got[87:80]));
        cmp("drive_shift_out", 16'(exp_d[95:88]), 16'(got[95:88]));
        cmp("steer_mode_out", 16'(exp_d[103:96]), 16'(got[103:96]));
        cmp("ehb_status_out", 16'(exp_d[111:104]), 16'(got[111:104]));
        cmp("ehb_mode_out", 16'(exp_d[119:112]), 16'(got[119:112]));
        cmp("pressure_valid_out", 16'(exp_d[120]), 16'(got[120]));
        cmp("brake_fault_out", 16'(exp_d[128:121]), 16'(got[128:121]));
        cmp("pad", 16'(exp_d[135:129]), 16'(got[135:129]));
    endfunction

    function void cmp(string fname, logic [15:0] e, logic [15:0] a);
        if (e !== a) begin
            $error("%s: expected %h, got %h", fname, e, a);
            fail_cnt++;
        end
    endfunction
endclass

module chassis_lag_model_step_tb;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_axis_tvalid = 0;
    logic         o_s_axis_tready;
    logic [135:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 0;
    logic [135:0] o_m_axis_tdata;
    logic         i_cfg_valid = 0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [11:0]  i_cfg_data = '0;

    lag_scoreboard tick_sb = new();
    int            send_idle_pct, recv_idle_pct;

    chassis_lag_model_step uut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    initial begin
        #200_000_000;
        $display("Verification failed");
        $finish;
    end

    // result side: sample at rising edge, drive ready at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tick_sb.check_result(o_m_axis_tdata);
    end

    always @(negedge i_clk) begin
        if (i_rst_n)
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // valid stays up until the next task drops or reuses it
    task automatic send_tick(logic [135:0] d);
        i_cfg_valid <= 0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        i_s_axis_tdata  <= d;
        i_s_axis_tvalid <= 1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tick_sb.note_tick(d);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 0;
        i_cfg_valid     <= 0;
        while (tick_sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_reg(clms_pkg::t_cfg_index idx, logic [11:0] val);
        i_s_axis_tvalid <= 0;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        tick_sb.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    function automatic logic [135:0] make_tick(logic [15:0] dt, logic [15:0] tv,
                                               logic [15:0] ts, logic [15:0] tp,
                                               logic [15:0] tb);
        logic [135:0] d;
        d = '0;
        d[79:0]   = {tb, tp, ts, tv, dt};
        d[128:80] = 49'({$urandom, $urandom});
        return d;
    endfunction

    // mostly realistic ticks, some full-range
    function automatic logic [135:0] rand_tick();
        logic [15:0] dt;
        case ($urandom_range(9))
            0:       dt = 16'($urandom);
            1:       dt = $urandom_range(1) ? 16'd0 : 16'hFFFF;
            default: dt = 16'($urandom_range(1000, 20000));
        endcase
        return make_tick(dt,
                         $urandom_range(2) ? 16'($urandom_range(3000)) : 16'($urandom),
                         16'($urandom),
                         $urandom_range(1) ? 16'($urandom_range(2000)) : 16'($urandom),
                         16'($urandom));
    endfunction

    task automatic random_cfg();
        write_reg(clms_pkg::CFG_SPEED_TAU_RISE, 12'($urandom_range(1023)));
        write_reg(clms_pkg::CFG_SPEED_TAU_FALL,
                  $urandom_range(3) == 0 ? 12'd0 : 12'($urandom_range(1023)));
        write_reg(clms_pkg::CFG_STEER_TAU_RISE, 12'($urandom_range(1023)));
        write_reg(clms_pkg::CFG_STEER_TAU_FALL, 12'($urandom_range(1023)));
        write_reg(clms_pkg::CFG_BRAKE_TAU, 12'($urandom_range(1023)));
        write_reg(clms_pkg::CFG_ACCEL_LIMIT, 12'($urandom_range(4095)));
        write_reg(clms_pkg::CFG_BRAKE_DECEL_GAIN, 12'($urandom_range(1023)));
    endtask

    initial begin
        tick_sb.init();
        send_idle_pct = 21;
        recv_idle_pct = 81;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;

        // directed: defaults, extremes, zero step, clamp, saturation
        send_tick(make_tick(16'd10000, 16'd1000, 16'd500, 16'd100, 16'd200));
        send_tick(make_tick(16'd0, 16'd65535, 16'h8000, 16'd65535, 16'd65535));
        send_tick(make_tick(16'd65535, 16'd65535, 16'h7FFF, 16'd65535, 16'd65535));
        send_tick(make_tick(16'd1, 16'd0, 16'h8000, 16'd0, 16'd0));
        send_tick(make_tick(16'd65535, 16'd0, 16'd0, 16'd0, 16'd0));
        drain();
        // zero taus, max limit: demand passes straight, big acceleration
        for (int r = 0; r < 7; r++) write_reg(clms_pkg::t_cfg_index'(r), 12'd0);
        write_reg(clms_pkg::CFG_ACCEL_LIMIT, 12'hFFF);
        write_reg(clms_pkg::CFG_BRAKE_DECEL_GAIN, 12'h3FF);
        send_tick(make_tick(16'd1, 16'd65535, 16'h7FFF, 16'd65535, 16'd65535));
        send_tick(make_tick(16'd1, 16'd0, 16'h8000, 16'd0, 16'd0));
        send_tick(make_tick(16'd65535, 16'd40000, 16'hFFFF, 16'd65535, 16'd1));
        send_tick(make_tick(16'd65535, 16'd100, 16'd1, 16'd0, 16'd0));
        send_tick(make_tick(16'd0, 16'd5000, 16'd0, 16'd0, 16'd0));
        drain();
        // max taus, unknown index ignored
        for (int r = 0; r < 7; r++) write_reg(clms_pkg::t_cfg_index'(r), 12'hFFF);
        write_reg(clms_pkg::t_cfg_index'(7), 12'h5A5);
        for (int k = 0; k < 8; k++) send_tick(rand_tick());
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 81;
                recv_idle_pct = 21;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 0) begin
                for (int r = 0; r < 7; r++)
                    write_reg(clms_pkg::t_cfg_index'(r),
                              r == int'(clms_pkg::CFG_ACCEL_LIMIT) ? 12'd300 : 12'd100);
            end else begin
                random_cfg();
            end
            for (int k = 0; k < 205; k++) send_tick(rand_tick());
            drain();
        end

        if (tick_sb.fail_cnt == 0 && tick_sb.pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/clms_pkg.sv
rtl/clms_div.sv
rtl/chassis_lag_model_step.sv
tb/chassis_lag_model_step_tb.sv
